[hdl/stw_pkg.sv]
// ----------------------------------------------------------------------------
// stw_pkg: shared types and constants of the settable wall clock
// command codes, character codes, field widths and time-unit constants
// ----------------------------------------------------------------------------
package stw_pkg;

  // beat field widths
  localparam int OP_W   = 2;
  localparam int TICK_W = 32;
  localparam int CHAR_W = 8;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int BASE_W = 19;

  // command codes
  typedef enum logic [OP_W-1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_SET   = 2'd2,
    OP_STOP  = 2'd3
  } stw_op_t;

  // ascii codes used by the set command
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'd58;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;

  // time units
  localparam int SEC_PER_HOUR  = 3600;
  localparam int SEC_PER_MIN   = 60;
  localparam int HOURS_PER_DAY = 24;

endpackage

[hdl/stw_in_if.sv]
// ----------------------------------------------------------------------------
// stw_in_if: command channel of the settable wall clock
// valid/ready channel carrying one command beat with the tick count
// ----------------------------------------------------------------------------
interface stw_in_if;
  import stw_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [TICK_W-1:0] tick_count;
  logic [CHAR_W-1:0] hour_tens_char;
  logic [CHAR_W-1:0] hour_ones_char;
  logic [CHAR_W-1:0] first_separator;
  logic [CHAR_W-1:0] minute_tens_char;
  logic [CHAR_W-1:0] minute_ones_char;
  logic [CHAR_W-1:0] second_separator;
  logic [CHAR_W-1:0] second_tens_char;
  logic [CHAR_W-1:0] second_ones_char;
  logic [CHAR_W-1:0] terminator_char;

  modport source (
    output valid, op, tick_count, hour_tens_char, hour_ones_char, first_separator,
           minute_tens_char, minute_ones_char, second_separator, second_tens_char,
           second_ones_char, terminator_char,
    input  ready
  );

  modport sink (
    input  valid, op, tick_count, hour_tens_char, hour_ones_char, first_separator,
           minute_tens_char, minute_ones_char, second_separator, second_tens_char,
           second_ones_char, terminator_char,
    output ready
  );

endinterface

[hdl/stw_out_if.sv]
// ----------------------------------------------------------------------------
// stw_out_if: time-of-day channel of the settable wall clock
// valid/ready channel carrying one hh:mm:ss beat
// ----------------------------------------------------------------------------
interface stw_out_if;
  import stw_pkg::*;

  logic              valid;
  logic              ready;
  logic [HOUR_W-1:0] hours;
  logic [MIN_W-1:0]  minutes;
  logic [SEC_W-1:0]  seconds;

  modport source (
    output valid, hours, minutes, seconds,
    input  ready
  );

  modport sink (
    input  valid, hours, minutes, seconds,
    output ready
  );

endinterface

[hdl/stw_const_div.sv]
// ----------------------------------------------------------------------------
// stw_const_div: pipelined divider by a constant
// reciprocal multiply in two half-width products, remainder and one-step fixup
// ----------------------------------------------------------------------------
module stw_const_div #(
  parameter  int W  = 32,
  parameter  int D  = 2000,
  parameter  int SW = 1,
  localparam int DW = $clog2(D + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [W-1:0]  x_i,
  input  logic [SW-1:0] side_i,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [W-1:0]  q_o,
  output logic [DW-1:0] r_o,
  output logic [SW-1:0] side_o
);

  // reciprocal: floor(2^(W+L) / D) with L = floor(log2(D)), at most 2^W
  localparam int L   = $clog2(D + 1) - 1;
  localparam int H   = W / 2;
  localparam int HI  = W - H;
  localparam int PHW = HI + W + 1;
  localparam int PLW = H + W + 1;
  localparam int PW  = 2 * W + 1;
  localparam int QW  = W + DW;
  localparam logic [63:0] MFULL = (64'd1 << (W + L)) / 64'(D);
  localparam logic [W:0]      M    = MFULL[W:0];
  localparam logic [DW-1:0]   DV   = DW'(D);
  localparam logic [DW:0]     DV1  = (DW + 1)'(D);

  logic [4:0] v_r;
  logic [4:0] en;

  logic [W-1:0]   x0_r, x1_r, x2_r;
  logic [SW-1:0]  sd0_r, sd1_r, sd2_r, sd3_r, sd4_r;
  logic [PHW-1:0] phi_r, phi_nxt;
  logic [PLW-1:0] plo_r, plo_nxt;
  logic [PW-1:0]  full;
  logic [W-1:0]   qe2_r, qe2_nxt, qe3_r, q4_r, q4_nxt;
  logic [QW-1:0]  prd;
  logic [W-1:0]   diff;
  logic [DW:0]    r3_r, r3_nxt;
  logic [DW-1:0]  r4_r, r4_nxt;

  // a stage loads when empty or when its contents move on
  assign en[4]    = !v_r[4] || out_ready;
  assign en[3]    = !v_r[3] || en[4];
  assign en[2]    = !v_r[2] || en[3];
  assign en[1]    = !v_r[1] || en[2];
  assign en[0]    = !v_r[0] || en[1];
  assign in_ready = en[0];

  // partial products of the reciprocal multiply
  assign phi_nxt = PHW'(x0_r[W-1:H]) * PHW'(M);
  assign plo_nxt = PLW'(x0_r[H-1:0]) * PLW'(M);

  // estimate, low by at most one
  assign full    = (PW'(phi_r) << H) + PW'(plo_r);
  assign qe2_nxt = W'(full >> (W + L));

  // remainder of the estimate, below twice the divisor
  assign prd    = QW'(qe2_r) * QW'(DV);
  assign diff   = x2_r - prd[W-1:0];
  assign r3_nxt = diff[DW:0];

  always_comb begin
    if (r3_r >= DV1) begin
      q4_nxt = qe3_r + W'(1);
      r4_nxt = DW'(r3_r - DV1);
    end else begin
      q4_nxt = qe3_r;
      r4_nxt = r3_r[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
      if (en[4]) v_r[4] <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0_r  <= x_i;
      sd0_r <= side_i;
    end
    if (en[1]) begin
      phi_r <= phi_nxt;
      plo_r <= plo_nxt;
      x1_r  <= x0_r;
      sd1_r <= sd0_r;
    end
    if (en[2]) begin
      qe2_r <= qe2_nxt;
      x2_r  <= x1_r;
      sd2_r <= sd1_r;
    end
    if (en[3]) begin
      qe3_r <= qe2_r;
      r3_r  <= r3_nxt;
      sd3_r <= sd2_r;
    end
    if (en[4]) begin
      q4_r  <= q4_nxt;
      r4_r  <= r4_nxt;
      sd4_r <= sd3_r;
    end
  end

  assign out_valid = v_r[4];
  assign q_o       = q4_r;
  assign r_o       = r4_r;
  assign side_o    = sd4_r;

endmodule

[hdl/settable_wall_clock.sv]
// ----------------------------------------------------------------------------
// settable_wall_clock: hh:mm:ss wall clock driven by a free-running tick count
// applies reset, set and stop commands and reports the time of day per beat
// ----------------------------------------------------------------------------
// Each command beat carries an op code and the current tick count. The op is
// applied when the beat is accepted: reset snaps the reference to a whole
// second and clears the time, a valid "hh:mm:ss" set loads the base time and
// takes the tick as reference, stop blanks the display, and an invalid set is
// ignored. While the display is on, every command beat yields one result
// beat with hours (mod 24), minutes and seconds; with the display off no
// result beat is produced. One beat is taken per clock cycle unless the
// chain stalls. The time is worked out by a chain of five constant-divider
// units (reference rounding, ticks to seconds, seconds to hours, hours mod
// 24, minutes and seconds), each five registers deep. Back pressure on the
// result channel fills the chain before the command channel stalls.
// ----------------------------------------------------------------------------
module settable_wall_clock #(
  parameter int TICKS_PER_SECOND = 2000
) (
  input logic      clk,
  input logic      rst_n,
  stw_in_if.sink   in_ch,
  stw_out_if.source out_ch
);
  import stw_pkg::*;

  localparam int TDW   = $clog2(TICKS_PER_SECOND + 1);
  localparam int TOT_W = TICK_W + 1;          // base plus elapsed seconds
  localparam int HRS_W = 21;                  // whole hours, below 2^21
  localparam int RSH_W = $clog2(SEC_PER_HOUR + 1);
  localparam int S1_W  = 2 * TICK_W + 1 + BASE_W;

  // digit weights of the set string
  localparam logic [BASE_W-1:0] W_H1 = BASE_W'(10 * SEC_PER_HOUR);
  localparam logic [BASE_W-1:0] W_H0 = BASE_W'(SEC_PER_HOUR);
  localparam logic [BASE_W-1:0] W_M1 = BASE_W'(10 * SEC_PER_MIN);
  localparam logic [BASE_W-1:0] W_M0 = BASE_W'(SEC_PER_MIN);
  localparam logic [BASE_W-1:0] W_S1 = BASE_W'(10);

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [BASE_W-1:0] digit_val(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = c - CHAR_ZERO;
    return BASE_W'(d[3:0]);
  endfunction

  // clock state
  logic [TICK_W-1:0] ref_raw_r, ref_raw_nxt;   // tick of the last reset or set
  logic              rnd_r, rnd_nxt;           // reference snaps to a second
  logic [BASE_W-1:0] base_r, base_nxt;
  logic              disp_r, disp_nxt;

  logic              accept;
  logic              set_ok;
  logic [BASE_W-1:0] set_base;

  // ready of each unit, passed back up the chain
  logic              d2_rdy, d3_rdy, d4_rdy, d5_rdy;

  assign accept = in_ch.valid && in_ch.ready;

  // the set string must be dd:dd:dd followed by a nul
  assign set_ok = (in_ch.first_separator == CHAR_COLON) &&
                  (in_ch.second_separator == CHAR_COLON) &&
                  (in_ch.terminator_char == CHAR_NUL) &&
                  is_digit(in_ch.hour_tens_char) && is_digit(in_ch.hour_ones_char) &&
                  is_digit(in_ch.minute_tens_char) && is_digit(in_ch.minute_ones_char) &&
                  is_digit(in_ch.second_tens_char) && is_digit(in_ch.second_ones_char);

  assign set_base = digit_val(in_ch.hour_tens_char) * W_H1 +
                    digit_val(in_ch.hour_ones_char) * W_H0 +
                    digit_val(in_ch.minute_tens_char) * W_M1 +
                    digit_val(in_ch.minute_ones_char) * W_M0 +
                    digit_val(in_ch.second_tens_char) * W_S1 +
                    digit_val(in_ch.second_ones_char);

  // command decode
  always_comb begin
    ref_raw_nxt = ref_raw_r;
    rnd_nxt     = rnd_r;
    base_nxt    = base_r;
    disp_nxt    = disp_r;
    case (stw_op_t'(in_ch.op))
      OP_RESET: begin
        ref_raw_nxt = in_ch.tick_count;
        rnd_nxt     = 1'b1;
        base_nxt    = '0;
        disp_nxt    = 1'b1;
      end
      OP_SET: begin
        if (set_ok) begin
          ref_raw_nxt = in_ch.tick_count;
          rnd_nxt     = 1'b0;
          base_nxt    = set_base;
          disp_nxt    = 1'b1;
        end
      end
      OP_STOP: begin
        disp_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_raw_r <= '0;
      rnd_r     <= 1'b0;
      base_r    <= '0;
      disp_r    <= 1'b1;
    end else if (accept) begin
      ref_raw_r <= ref_raw_nxt;
      rnd_r     <= rnd_nxt;
      base_r    <= base_nxt;
      disp_r    <= disp_nxt;
    end
  end

  // unit 1: remainder of the reference tick, for the whole-second snap
  // each beat carries its own copy of the clock state down the chain
  logic              d1_rdy, d1_vld;
  logic [TDW-1:0]    d1_r;
  logic [S1_W-1:0]   d1_side;
  logic [TICK_W-1:0] d1_tick, d1_ref, d1_ref_raw, d1_elapsed;
  logic              d1_rnd;
  logic [BASE_W-1:0] d1_base;

  assign in_ch.ready = d1_rdy;

  stw_const_div #(
    .W  (TICK_W),
    .D  (TICKS_PER_SECOND),
    .SW (S1_W + 0)
  ) u_div_ref (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid && disp_nxt),
    .in_ready  (d1_rdy),
    .x_i       (ref_raw_nxt),
    .side_i    ({in_ch.tick_count, rnd_nxt, base_nxt, ref_raw_nxt}),
    .out_valid (d1_vld),
    .out_ready (d2_rdy),
    .q_o       (),
    .r_o       (d1_r),
    .side_o    (d1_side)
  );

  assign {d1_tick, d1_rnd, d1_base} = d1_side[S1_W-1:TICK_W];
  assign d1_ref_raw = d1_side[TICK_W-1:0];

  // elapsed ticks wrap modulo 2^32
  assign d1_ref     = d1_rnd ? (d1_ref_raw - TICK_W'(d1_r)) : d1_ref_raw;
  assign d1_elapsed = d1_tick - d1_ref;

  // unit 2: elapsed ticks to whole seconds
  logic              d2_vld;
  logic [TICK_W-1:0] d2_q;
  logic [BASE_W-1:0] d2_base;
  logic [TOT_W-1:0]  d2_total;

  stw_const_div #(
    .W  (TICK_W),
    .D  (TICKS_PER_SECOND),
    .SW (BASE_W)
  ) u_div_sec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d1_vld),
    .in_ready  (d2_rdy),
    .x_i       (d1_elapsed),
    .side_i    (d1_base),
    .out_valid (d2_vld),
    .out_ready (d3_rdy),
    .q_o       (d2_q),
    .r_o       (),
    .side_o    (d2_base)
  );

  assign d2_total = TOT_W'(d2_base) + TOT_W'(d2_q);

  // unit 3: seconds to whole hours and seconds within the hour
  logic              d3_vld;
  logic [TOT_W-1:0]  d3_q;
  logic [RSH_W-1:0]  d3_r;

  stw_const_div #(
    .W  (TOT_W),
    .D  (SEC_PER_HOUR),
    .SW (1)
  ) u_div_hour (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d2_vld),
    .in_ready  (d3_rdy),
    .x_i       (d2_total),
    .side_i    (1'b0),
    .out_valid (d3_vld),
    .out_ready (d4_rdy),
    .q_o       (d3_q),
    .r_o       (d3_r),
    .side_o    ()
  );

  // unit 4: hours modulo one day
  logic              d4_vld;
  logic [HOUR_W-1:0] d4_r;
  logic [RSH_W-1:0]  d4_rsh;

  stw_const_div #(
    .W  (HRS_W),
    .D  (HOURS_PER_DAY),
    .SW (RSH_W)
  ) u_div_day (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d3_vld),
    .in_ready  (d4_rdy),
    .x_i       (d3_q[HRS_W-1:0]),
    .side_i    (d3_r),
    .out_valid (d4_vld),
    .out_ready (d5_rdy),
    .q_o       (),
    .r_o       (d4_r),
    .side_o    (d4_rsh)
  );

  // unit 5: seconds within the hour to minutes and seconds
  logic              d5_vld;
  logic [RSH_W-1:0]  d5_q;
  logic [SEC_W-1:0]  d5_r;
  logic [HOUR_W-1:0] d5_hours;

  stw_const_div #(
    .W  (RSH_W),
    .D  (SEC_PER_MIN),
    .SW (HOUR_W)
  ) u_div_min (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d4_vld),
    .in_ready  (d5_rdy),
    .x_i       (d4_rsh),
    .side_i    (d4_r),
    .out_valid (d5_vld),
    .out_ready (out_ch.ready),
    .q_o       (d5_q),
    .r_o       (d5_r),
    .side_o    (d5_hours)
  );

  // result beat straight from the last unit's output register
  assign out_ch.valid   = d5_vld;
  assign out_ch.hours   = d5_hours;
  assign out_ch.minutes = d5_q[MIN_W-1:0];
  assign out_ch.seconds = d5_r;

endmodule
